// File: rtl/core/mstt_pkg.sv
// ----------------------------------------------------------------------------
// mstt_pkg
// Shared types, constants and helpers of the multi-slot task timer.
// ----------------------------------------------------------------------------
package mstt_pkg;

    localparam int SLOTS     = 16;
    localparam int TIME_BITS = 48;
    localparam int ID_BITS   = 16;
    localparam int SLOT_W    = $clog2(SLOTS);

    localparam logic [2:0] OP_AT     = 3'd0;
    localparam logic [2:0] OP_DELAY  = 3'd1;
    localparam logic [2:0] OP_EVERY  = 3'd2;
    localparam logic [2:0] OP_CANCEL = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic [2:0] EV_SCHEDULED = 3'd0;
    localparam logic [2:0] EV_FULL      = 3'd1;
    localparam logic [2:0] EV_FOUND     = 3'd2;
    localparam logic [2:0] EV_MISSING   = 3'd3;
    localparam logic [2:0] EV_RUN       = 3'd4;
    localparam logic [2:0] EV_CLEANUP   = 3'd5;
    localparam logic [2:0] EV_TICK_DONE = 3'd6;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [ID_BITS-1:0]   id_t;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [47:0] time_value;
        logic [47:0] now_time;
        logic [15:0] task_id;
        logic        has_cleanup;
        logic        run_immediately;
        logic        skip_if_late;
    } in_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [15:0] event_id;
        logic [47:0] next_deadline;
        logic        has_deadline;
        logic        last;
    } out_t;

    typedef enum logic [1:0] {
        JOB_ADD,
        JOB_CANCEL,
        JOB_TICK
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        time_t     next_run;
        time_t     interval;
        time_t     now;
        id_t       tid;
        logic      skip;
        logic      cleanup;
    } job_t;

    function automatic time_t sat_add(input time_t a, input time_t b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[TIME_BITS]) begin
            return '1;
        end
        return s[TIME_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/multi_slot_task_timer_top.sv
// ----------------------------------------------------------------------------
// multi_slot_task_timer_top
// Sixteen-slot one-shot and periodic timer table with tick-driven run events.
// ----------------------------------------------------------------------------
// s_ channel: one transfer per command (schedule at time, after delay, every
// interval, cancel, tick). Unknown opcodes are taken and dropped.
// m_ channel: result events, last set on the final event of each command.
// A two-entry job queue sits between the input side and the slot sequencer,
// so commands are taken while the sequencer works or the receiver stalls.
// Cancel searches the slots in order until the id matches; tick walks every
// slot, with a cleanup step for each freed one-shot slot that has cleanup
// and an update step for each due periodic slot; a due periodic slot with
// skip-if-late first waits on the one-bit-per-cycle remainder unit.
// Items are worked on one at a time by the sequencer.
// A stalled receiver holds the sequencer at its next event; nothing is lost.
// Reset (aresetn low, synchronous) clears all slots, the id counter, the
// queue and the output valid flag.
// ----------------------------------------------------------------------------
module multi_slot_task_timer_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mstt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output mstt_pkg::out_t m_data
);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    mstt_pkg::job_t push_job;
    mstt_pkg::job_t head_job;

    mstt_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    mstt_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (head_job)
    );

    mstt_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_job   (head_job),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: rtl/core/mstt_front.sv
// ----------------------------------------------------------------------------
// mstt_front
// Takes input transfers, drops unknown opcodes and turns the rest into jobs.
// ----------------------------------------------------------------------------
module mstt_front (
    input  logic              s_valid,
    output logic              s_ready,
    input  mstt_pkg::in_t     s_data,
    input  logic              q_full,
    output logic              q_push,
    output mstt_pkg::job_t    q_job
);

    mstt_pkg::time_t tv;
    mstt_pkg::time_t now;
    mstt_pkg::time_t later;
    logic            known;

    assign tv      = s_data.time_value;
    assign now     = s_data.now_time;
    assign later   = mstt_pkg::sat_add(now, tv);
    assign s_ready = !q_full;
    assign known   = s_data.opcode <= mstt_pkg::OP_TICK;
    assign q_push  = s_valid && !q_full && known;

    always_comb begin
        q_job          = '0;
        q_job.now      = now;
        q_job.tid      = s_data.task_id;
        q_job.cleanup  = s_data.has_cleanup;
        q_job.kind     = mstt_pkg::JOB_ADD;
        unique case (s_data.opcode)
            mstt_pkg::OP_AT: begin
                q_job.next_run = tv;
            end
            mstt_pkg::OP_DELAY: begin
                q_job.next_run = later;
            end
            mstt_pkg::OP_EVERY: begin
                q_job.next_run = s_data.run_immediately ? now : later;
                q_job.interval = tv;
                q_job.skip     = s_data.skip_if_late;
            end
            mstt_pkg::OP_CANCEL: begin
                q_job.kind = mstt_pkg::JOB_CANCEL;
            end
            default: begin
                q_job.kind = mstt_pkg::JOB_TICK;
            end
        endcase
    end

endmodule

// File: rtl/core/mstt_queue.sv
// ----------------------------------------------------------------------------
// mstt_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module mstt_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  mstt_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output mstt_pkg::job_t head
);

    mstt_pkg::job_t mem_reg [2];
    logic           wr_reg;
    logic           rd_reg;
    logic [1:0]     count_reg;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign head      = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= 1'b0;
            rd_reg    <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (push) begin
                mem_reg[wr_reg] <= push_job;
                wr_reg          <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// File: rtl/core/mstt_div.sv
// ----------------------------------------------------------------------------
// mstt_div
// Restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module mstt_div (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  mstt_pkg::time_t dividend,
    input  mstt_pkg::time_t divisor,
    output logic            done,
    output mstt_pkg::time_t remainder
);

    localparam int CNT_W = $clog2(mstt_pkg::TIME_BITS + 1);

    logic [mstt_pkg::TIME_BITS:0]   rem_reg;
    mstt_pkg::time_t                dvd_reg;
    mstt_pkg::time_t                dsr_reg;
    logic [CNT_W-1:0]               cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [mstt_pkg::TIME_BITS:0]   trial;
    logic [mstt_pkg::TIME_BITS:0]   diff;

    assign trial     = {rem_reg[mstt_pkg::TIME_BITS-1:0], dvd_reg[mstt_pkg::TIME_BITS-1]};
    assign diff      = trial - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign remainder = rem_reg[mstt_pkg::TIME_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                dvd_reg  <= dividend;
                dsr_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg <= diff[mstt_pkg::TIME_BITS] ? trial : diff;
                dvd_reg <= {dvd_reg[mstt_pkg::TIME_BITS-2:0], 1'b0};
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(mstt_pkg::TIME_BITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

// File: rtl/core/mstt_back.sv
// ----------------------------------------------------------------------------
// mstt_back
// Slot table and sequencer: schedules, cancels and walks the slots on tick.
// ----------------------------------------------------------------------------
module mstt_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  mstt_pkg::job_t q_job,
    output logic           q_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output mstt_pkg::out_t m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_CANCEL_SCAN,
        ST_CANCEL_CLEAN,
        ST_CANCEL_FOUND,
        ST_CANCEL_MISS,
        ST_TICK_CHECK,
        ST_TICK_CLEAN,
        ST_TICK_DIV,
        ST_TICK_UPD,
        ST_TICK_DONE
    } state_t;

    localparam logic [mstt_pkg::SLOT_W-1:0] LAST_IDX = mstt_pkg::SLOT_W'(mstt_pkg::SLOTS - 1);

    state_t                      state_reg;
    mstt_pkg::job_t              job_reg;
    logic [mstt_pkg::SLOT_W-1:0] idx_reg;
    logic [mstt_pkg::SLOTS-1:0]  act_reg;
    mstt_pkg::id_t               id_reg    [mstt_pkg::SLOTS];
    mstt_pkg::time_t             nr_reg    [mstt_pkg::SLOTS];
    mstt_pkg::time_t             iv_reg    [mstt_pkg::SLOTS];
    logic                        skip_reg  [mstt_pkg::SLOTS];
    logic                        clean_reg [mstt_pkg::SLOTS];
    mstt_pkg::id_t               id_counter_reg;
    mstt_pkg::time_t             best_reg;
    logic                        any_reg;
    mstt_pkg::time_t             base_reg;
    logic                        out_valid_reg;
    mstt_pkg::out_t              out_reg;

    logic [mstt_pkg::SLOT_W-1:0] free_idx;
    logic                        full;
    logic                        out_free;
    mstt_pkg::id_t               cur_id;
    mstt_pkg::time_t             cur_nr;
    mstt_pkg::time_t             cur_iv;
    mstt_pkg::time_t             upd_nr;
    logic                        div_start;
    logic                        div_done;
    mstt_pkg::time_t             div_rem;

    assign m_valid  = out_valid_reg;
    assign m_data   = out_reg;
    assign out_free = !out_valid_reg || m_ready;
    assign q_pop    = state_reg == ST_IDLE && q_valid;
    assign cur_id   = id_reg[idx_reg];
    assign cur_nr   = nr_reg[idx_reg];
    assign cur_iv   = iv_reg[idx_reg];
    assign upd_nr   = mstt_pkg::sat_add(base_reg, cur_iv);

    assign div_start = state_reg == ST_TICK_CHECK && act_reg[idx_reg] && cur_nr <= job_reg.now
                       && out_free && cur_iv != '0 && skip_reg[idx_reg];

    // lowest free slot
    always_comb begin
        free_idx = '0;
        full     = 1'b1;
        for (int i = mstt_pkg::SLOTS - 1; i >= 0; i--) begin
            if (!act_reg[i]) begin
                free_idx = mstt_pkg::SLOT_W'(i);
                full     = 1'b0;
            end
        end
    end

    mstt_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (job_reg.now - cur_nr),
        .divisor   (cur_iv),
        .done      (div_done),
        .remainder (div_rem)
    );

    function automatic mstt_pkg::out_t make_ev(input logic [2:0] kind, input mstt_pkg::id_t id,
                                              input mstt_pkg::time_t dl, input logic has,
                                              input logic last);
        mstt_pkg::out_t r;
        r.event_kind    = kind;
        r.event_id      = id;
        r.next_deadline = dl;
        r.has_deadline  = has;
        r.last          = last;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            act_reg        <= '0;
            id_counter_reg <= '0;
            out_valid_reg  <= 1'b0;
            idx_reg        <= '0;
        end else begin
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        job_reg  <= q_job;
                        idx_reg  <= '0;
                        best_reg <= '1;
                        any_reg  <= 1'b0;
                        unique case (q_job.kind)
                            mstt_pkg::JOB_ADD:    state_reg <= ST_ADD;
                            mstt_pkg::JOB_CANCEL: state_reg <= ST_CANCEL_SCAN;
                            default:              state_reg <= ST_TICK_CHECK;
                        endcase
                    end
                end
                ST_ADD: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        if (full) begin
                            out_reg <= make_ev(mstt_pkg::EV_FULL, '0, '0, 1'b0, 1'b1);
                        end else begin
                            out_reg <= make_ev(mstt_pkg::EV_SCHEDULED, id_counter_reg, '0,
                                               1'b0, 1'b1);
                            act_reg[free_idx]   <= 1'b1;
                            id_reg[free_idx]    <= id_counter_reg;
                            nr_reg[free_idx]    <= job_reg.next_run;
                            iv_reg[free_idx]    <= job_reg.interval;
                            skip_reg[free_idx]  <= job_reg.skip;
                            clean_reg[free_idx] <= job_reg.cleanup;
                            id_counter_reg      <= id_counter_reg + 1'b1;
                        end
                    end
                end
                ST_CANCEL_SCAN: begin
                    if (act_reg[idx_reg] && cur_id == job_reg.tid) begin
                        act_reg[idx_reg] <= 1'b0;
                        state_reg <= clean_reg[idx_reg] ? ST_CANCEL_CLEAN : ST_CANCEL_FOUND;
                    end else if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_CANCEL_MISS;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CANCEL_CLEAN: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg   <= make_ev(mstt_pkg::EV_CLEANUP, job_reg.tid, '0, 1'b0, 1'b0);
                        state_reg <= ST_CANCEL_FOUND;
                    end
                end
                ST_CANCEL_FOUND: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg   <= make_ev(mstt_pkg::EV_FOUND, job_reg.tid, '0, 1'b0, 1'b1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_CANCEL_MISS: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg   <= make_ev(mstt_pkg::EV_MISSING, job_reg.tid, '0, 1'b0, 1'b1);
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TICK_CHECK: begin
                    if (!act_reg[idx_reg]) begin
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_TICK_DONE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (cur_nr > job_reg.now) begin
                        any_reg <= 1'b1;
                        if (cur_nr < best_reg) begin
                            best_reg <= cur_nr;
                        end
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_TICK_DONE;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                    end else if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= make_ev(mstt_pkg::EV_RUN, cur_id, '0, 1'b0, 1'b0);
                        if (cur_iv == '0) begin
                            // one-shot: free the slot
                            act_reg[idx_reg] <= 1'b0;
                            if (clean_reg[idx_reg]) begin
                                state_reg <= ST_TICK_CLEAN;
                            end else if (idx_reg == LAST_IDX) begin
                                state_reg <= ST_TICK_DONE;
                            end else begin
                                idx_reg <= idx_reg + 1'b1;
                            end
                        end else if (skip_reg[idx_reg]) begin
                            state_reg <= ST_TICK_DIV;
                        end else begin
                            base_reg  <= cur_nr;
                            state_reg <= ST_TICK_UPD;
                        end
                    end
                end
                ST_TICK_CLEAN: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= make_ev(mstt_pkg::EV_CLEANUP, cur_id, '0, 1'b0, 1'b0);
                        if (idx_reg == LAST_IDX) begin
                            state_reg <= ST_TICK_DONE;
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_TICK_CHECK;
                        end
                    end
                end
                ST_TICK_DIV: begin
                    // last run not after now: now minus (now - run) mod interval
                    if (div_done) begin
                        base_reg  <= job_reg.now - div_rem;
                        state_reg <= ST_TICK_UPD;
                    end
                end
                ST_TICK_UPD: begin
                    nr_reg[idx_reg] <= upd_nr;
                    any_reg         <= 1'b1;
                    if (upd_nr < best_reg) begin
                        best_reg <= upd_nr;
                    end
                    if (idx_reg == LAST_IDX) begin
                        state_reg <= ST_TICK_DONE;
                    end else begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= ST_TICK_CHECK;
                    end
                end
                ST_TICK_DONE: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                        out_reg <= make_ev(mstt_pkg::EV_TICK_DONE, '0,
                                           any_reg ? best_reg : '0, any_reg, 1'b1);
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// File: tb/multi_slot_task_timer_top_test.sv
// ----------------------------------------------------------------------------
// multi_slot_task_timer_top_test
// Self-checking bench for the task timer: directed and random commands go in
// through a bursty driver, a stalling monitor compares every event with a
// software copy of the slot table.
// ----------------------------------------------------------------------------
module multi_slot_task_timer_top_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [47:0] TMAX = '1;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    mstt_pkg::in_t  s_data = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    mstt_pkg::out_t m_data;

    multi_slot_task_timer_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #2 aclk = ~aclk;

    // timer table copy
    logic        tbl_active [mstt_pkg::SLOTS];
    logic [15:0] tbl_id [mstt_pkg::SLOTS];
    logic [47:0] tbl_next [mstt_pkg::SLOTS];
    logic [47:0] tbl_ival [mstt_pkg::SLOTS];
    logic        tbl_skip [mstt_pkg::SLOTS];
    logic        tbl_clean [mstt_pkg::SLOTS];
    logic [15:0] next_id;

    mstt_pkg::in_t  cmd_queue[$];
    mstt_pkg::out_t event_queue[$];
    int   errors = 0;
    int   idle_cycles = 0;
    bit   hold_off = 0;
    int   burst_left = 0;
    int   gap_left = 0;
    int   stall_phase = 0;

    function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? TMAX : s[47:0];
    endfunction

    function automatic void queue_cmd(mstt_pkg::in_t c);
        cmd_queue.insert(cmd_queue.size(), c);
    endfunction

    function automatic void push_event(logic [2:0] k, logic [15:0] id,
                                       logic [47:0] dl, logic hd);
        mstt_pkg::out_t e;
        e.event_kind = k;
        e.event_id = id;
        e.next_deadline = dl;
        e.has_deadline = hd;
        e.last = 1'b0;
        event_queue.insert(event_queue.size(), e);
    endfunction

    function automatic void add_timer(logic [47:0] nr, logic [47:0] iv,
                                      logic sk, logic cl);
        for (int s = 0; s < mstt_pkg::SLOTS; s++) begin
            if (!tbl_active[s]) begin
                tbl_active[s] = 1'b1;
                tbl_id[s] = next_id;
                tbl_next[s] = nr;
                tbl_ival[s] = iv;
                tbl_skip[s] = sk;
                tbl_clean[s] = cl;
                push_event(mstt_pkg::EV_SCHEDULED, next_id, '0, 1'b0);
                next_id++;
                return;
            end
        end
        push_event(mstt_pkg::EV_FULL, '0, '0, 1'b0);
    endfunction

    function automatic void predict_events(mstt_pkg::in_t c);
        int before_n;
        logic found;
        logic any;
        logic [47:0] best;
        logic [47:0] diff;
        logic [47:0] base;
        before_n = event_queue.size();
        found = 1'b0;
        any = 1'b0;
        best = TMAX;
        case (c.opcode)
            mstt_pkg::OP_AT: add_timer(c.time_value, '0, 1'b0, c.has_cleanup);
            mstt_pkg::OP_DELAY: add_timer(add_sat(c.now_time, c.time_value), '0, 1'b0,
                                          c.has_cleanup);
            mstt_pkg::OP_EVERY: add_timer(c.run_immediately ? c.now_time :
                                          add_sat(c.now_time, c.time_value),
                                          c.time_value, c.skip_if_late, c.has_cleanup);
            mstt_pkg::OP_CANCEL: begin
                for (int s = 0; s < mstt_pkg::SLOTS; s++) begin
                    if (!found && tbl_active[s] && tbl_id[s] == c.task_id) begin
                        tbl_active[s] = 1'b0;
                        if (tbl_clean[s])
                            push_event(mstt_pkg::EV_CLEANUP, tbl_id[s], '0, 1'b0);
                        push_event(mstt_pkg::EV_FOUND, tbl_id[s], '0, 1'b0);
                        found = 1'b1;
                    end
                end
                if (!found) push_event(mstt_pkg::EV_MISSING, c.task_id, '0, 1'b0);
            end
            mstt_pkg::OP_TICK: begin
                for (int s = 0; s < mstt_pkg::SLOTS; s++) begin
                    if (tbl_active[s] && tbl_next[s] <= c.now_time) begin
                        push_event(mstt_pkg::EV_RUN, tbl_id[s], '0, 1'b0);
                        if (tbl_ival[s] != 0) begin
                            if (tbl_skip[s]) begin
                                diff = c.now_time - tbl_next[s];
                                base = tbl_next[s] + (diff / tbl_ival[s]) * tbl_ival[s];
                                tbl_next[s] = add_sat(base, tbl_ival[s]);
                            end else begin
                                tbl_next[s] = add_sat(tbl_next[s], tbl_ival[s]);
                            end
                        end else begin
                            tbl_active[s] = 1'b0;
                            if (tbl_clean[s])
                                push_event(mstt_pkg::EV_CLEANUP, tbl_id[s], '0, 1'b0);
                        end
                    end
                    if (tbl_active[s]) begin
                        any = 1'b1;
                        if (tbl_next[s] < best) best = tbl_next[s];
                    end
                end
                push_event(mstt_pkg::EV_TICK_DONE, '0, any ? best : '0, any);
            end
            default: ;
        endcase
        if (event_queue.size() > before_n)
            event_queue[event_queue.size()-1].last = 1'b1;
    endfunction

    // random command; ids and times drawn near recent activity
    function automatic mstt_pkg::in_t rand_cmd(logic [47:0] now);
        mstt_pkg::in_t c;
        int r;
        c.opcode = 3'($urandom_range(0, 4));
        r = $urandom_range(0, 9);
        if (r == 0) c.opcode = 3'($urandom_range(5, 7));
        c.now_time = now;
        case ($urandom_range(0, 5))
            0: c.time_value = 48'({$urandom, $urandom});
            1: c.time_value = TMAX - 48'($urandom_range(0, 3));
            2: c.time_value = '0;
            default: c.time_value = 48'($urandom_range(1, 60));
        endcase
        if (c.opcode == mstt_pkg::OP_AT && $urandom_range(0, 2) != 0)
            c.time_value = now + 48'($urandom_range(0, 80));
        c.task_id = $urandom_range(0, 3) == 0 ? 16'($urandom)
                                              : next_id - 16'($urandom_range(1, 20));
        c.has_cleanup = 1'($urandom_range(0, 1));
        c.run_immediately = 1'($urandom_range(0, 1));
        c.skip_if_late = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic mstt_pkg::in_t mk(logic [2:0] op, logic [47:0] tv, logic [47:0] now,
                                         logic [15:0] tid, logic cl, logic ri, logic sk);
        mstt_pkg::in_t c;
        c.opcode = op;
        c.time_value = tv;
        c.now_time = now;
        c.task_id = tid;
        c.has_cleanup = cl;
        c.run_immediately = ri;
        c.skip_if_late = sk;
        return c;
    endfunction

    // driver: bursts and gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (s_valid) predict_events(s_data);
            if (gap_left > 0) gap_left--;
            if (!hold_off && gap_left == 0 && cmd_queue.size() > 0) begin
                s_data <= cmd_queue.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // monitor: stalls on a repeating pattern with random stretches
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (event_queue.size() == 0) begin
                    $error("unexpected event kind %0d id %0d", m_data.event_kind,
                           m_data.event_id);
                    errors++;
                end else begin
                    mstt_pkg::out_t e;
                    e = event_queue.pop_front();
                    if (m_data.event_kind !== e.event_kind) begin
                        $error("event_kind exp %0d got %0d", e.event_kind,
                               m_data.event_kind);
                        errors++;
                    end
                    if (m_data.event_id !== e.event_id) begin
                        $error("event_id exp %0d got %0d", e.event_id, m_data.event_id);
                        errors++;
                    end
                    if (m_data.next_deadline !== e.next_deadline) begin
                        $error("next_deadline exp %0h got %0h", e.next_deadline,
                               m_data.next_deadline);
                        errors++;
                    end
                    if (m_data.has_deadline !== e.has_deadline) begin
                        $error("has_deadline exp %0d got %0d", e.has_deadline,
                               m_data.has_deadline);
                        errors++;
                    end
                    if (m_data.last !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_data.last);
                        errors++;
                    end
                end
            end
            stall_phase = (stall_phase + 1) % 64;
            m_ready <= stall_phase < 24 ? 1'b1
                       : (stall_phase % 5 != 0) && ($urandom_range(0, 2) != 0);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [47:0] now;
        for (int s = 0; s < mstt_pkg::SLOTS; s++) tbl_active[s] = 1'b0;
        next_id = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: each opcode, extremes, fourteen of sixteen slots in use, cancel with cleanup
        queue_cmd(mk(mstt_pkg::OP_TICK, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_AT, '0, '0, '0, 1'b1, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_DELAY, TMAX, TMAX, '1, 1'b1, 1'b1, 1'b1));
        queue_cmd(mk(mstt_pkg::OP_EVERY, 48'd10, 48'd5, '0, 1'b0, 1'b1, 1'b1));
        queue_cmd(mk(mstt_pkg::OP_EVERY, 48'd7, 48'd5, '0, 1'b1, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_EVERY, '0, 48'd3, '0, 1'b1, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_EVERY, TMAX, 48'd2, '0, 1'b0, 1'b0, 1'b1));
        queue_cmd(mk(mstt_pkg::OP_TICK, '0, 48'd1000, '0, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_CANCEL, '0, '0, 16'd3, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_CANCEL, '0, '0, 16'd3, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_CANCEL, '0, '0, 16'd1, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(3'd5, TMAX, TMAX, '1, 1'b1, 1'b1, 1'b1));
        queue_cmd(mk(3'd7, '0, '0, '0, 1'b0, 1'b0, 1'b0));
        for (int i = 0; i < 12; i++)
            queue_cmd(mk(mstt_pkg::OP_AT, 48'd2000 + 48'(i), '0, '0, i[0], 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_TICK, '0, TMAX, '0, 1'b0, 1'b0, 1'b0));
        queue_cmd(mk(mstt_pkg::OP_TICK, '0, TMAX, '0, 1'b0, 1'b0, 1'b0));
        wait (cmd_queue.size() == 0);

        // let everything drain once before random traffic
        hold_off = 1;
        wait (!s_valid);
        wait (event_queue.size() == 0);
        repeat (50) @(posedge aclk);
        hold_off = 0;

        now = 48'd100;
        for (int i = 0; i < 80; i++) begin
            if ($urandom_range(0, 5) == 0) now = now + 48'($urandom_range(0, 40));
            queue_cmd(rand_cmd(now));
            if ($urandom_range(0, 4) == 0) begin
                now = now + 48'($urandom_range(1, 120));
                queue_cmd(mk(mstt_pkg::OP_TICK, '0, now, '0, 1'b0, 1'b0, 1'b0));
            end
            if (i % 30 == 29) begin
                now = now + 48'd5000;
                queue_cmd(mk(mstt_pkg::OP_TICK, '0, now, '0, 1'b0, 1'b0, 1'b0));
            end
            wait (cmd_queue.size() < 4);
        end
        wait (cmd_queue.size() == 0);
        @(posedge aclk);
        wait (!s_valid);
        wait (event_queue.size() == 0);
        repeat (100) @(posedge aclk);
        if (errors == 0 && event_queue.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
